FILE: src/rms_power_fault_monitor_defines.svh
// Assertion macros shared by the monitor RTL.
`ifndef RMS_POWER_FAULT_MONITOR_DEFINES_SVH
`define RMS_POWER_FAULT_MONITOR_DEFINES_SVH

// Clocked assertion with asynchronous reset disable.
`define RPFM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define RPFM_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`RPFM_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

FILE: src/rpfm_pkg.sv
package rpfm_pkg;

	localparam int SPW       = 1000;
	localparam int CNT_W     = $clog2(SPW + 1);
	localparam int DIFF_W    = 12;
	localparam int SQ_W      = 2 * DIFF_W;
	localparam int SUM_W     = 36;
	localparam int ROOT_W    = SUM_W / 2;
	localparam int DREM_W    = $clog2(SPW + 1);
	localparam int DCNT_W    = $clog2(SUM_W);
	localparam int SREM_W    = ROOT_W + 2;
	localparam int SCNT_W    = $clog2(ROOT_W);
	localparam int CUR_W     = 12;
	localparam int VOLT_W    = 8;
	localparam int PWR_W     = 20;
	localparam int BAND_W    = 14;
	localparam int LIM_W     = 21;
	localparam int CW_PER_W  = 100;
	localparam int CNTB_W    = 8;
	localparam int SEC_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GATE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VOLTS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TRIP      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BACKOFF   = 3'd6;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_TICK   = 1'b1;

	typedef struct packed {
		logic start;
		logic done;
	} unit_hs_t;

endpackage

FILE: src/rpfm_sqacc.sv
module rpfm_sqacc (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           clear,
	input  logic [rpfm_pkg::DIFF_W-1:0]    diff,
	output logic [rpfm_pkg::SUM_W-1:0]     sum,
	output logic                           done
);

	logic                          busy_q;
	logic                          done_q;
	logic [rpfm_pkg::DIFF_W-1:0]   mplier_q;
	logic [rpfm_pkg::SQ_W-1:0]     mcand_q;
	logic [rpfm_pkg::SUM_W-1:0]    sum_q;
	logic                          last;

	assign last = (mplier_q[rpfm_pkg::DIFF_W-1:1] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			sum_q  <= '0;
		end else begin
			done_q <= busy_q && !clear && last;
			if (clear) begin
				sum_q <= '0;
			end else if (busy_q) begin
				// add one partial product per cycle, lsb of the multiplier first
				if (mplier_q[0])
					sum_q <= sum_q + rpfm_pkg::SUM_W'(mcand_q);
			end
			if (start)
				busy_q <= 1'b1;
			else if (busy_q && !clear && last)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mplier_q <= diff;
			mcand_q  <= rpfm_pkg::SQ_W'(diff);
		end else if (busy_q) begin
			mplier_q <= mplier_q >> 1;
			mcand_q  <= mcand_q << 1;
		end
	end

	assign sum  = sum_q;
	assign done = done_q;

endmodule

FILE: src/rpfm_div.sv
module rpfm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rpfm_pkg::SUM_W-1:0]  dividend,
	output logic [rpfm_pkg::SUM_W-1:0]  quotient,
	output logic                        done
);

	localparam logic [rpfm_pkg::DREM_W:0]   DIVISOR = (rpfm_pkg::DREM_W + 1)'(rpfm_pkg::SPW);
	localparam logic [rpfm_pkg::DCNT_W-1:0] LAST    = rpfm_pkg::DCNT_W'(rpfm_pkg::SUM_W - 1);

	logic                         busy_q;
	logic                         done_q;
	logic [rpfm_pkg::DCNT_W-1:0]  cnt_q;
	logic [rpfm_pkg::SUM_W-1:0]   dq_q;
	logic [rpfm_pkg::DREM_W-1:0]  rem_q;
	logic [rpfm_pkg::DREM_W:0]    rem_sh;
	logic                         ge;

	assign rem_sh = {rem_q, dq_q[rpfm_pkg::SUM_W-1]};
	assign ge     = (rem_sh >= DIVISOR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST)
					busy_q <= 1'b0;
			end
		end
	end

	// restoring division: dividend bits leave at the top, quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dq_q  <= {dq_q[rpfm_pkg::SUM_W-2:0], ge};
			rem_q <= ge ? rpfm_pkg::DREM_W'(rem_sh - DIVISOR) : rpfm_pkg::DREM_W'(rem_sh);
		end
	end

	assign quotient = dq_q;
	assign done     = done_q;

endmodule

FILE: src/rpfm_isqrt.sv
module rpfm_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [rpfm_pkg::SUM_W-1:0]   radicand,
	output logic [rpfm_pkg::ROOT_W-1:0]  root,
	output logic                         done
);

	localparam logic [rpfm_pkg::SCNT_W-1:0] LAST = rpfm_pkg::SCNT_W'(rpfm_pkg::ROOT_W - 1);

	logic                          busy_q;
	logic                          done_q;
	logic [rpfm_pkg::SCNT_W-1:0]   cnt_q;
	logic [rpfm_pkg::SUM_W-1:0]    rad_q;
	logic [rpfm_pkg::SREM_W-1:0]   rem_q;
	logic [rpfm_pkg::ROOT_W-1:0]   root_q;
	logic [rpfm_pkg::SREM_W+1:0]   rem_sh;
	logic [rpfm_pkg::SREM_W+1:0]   trial;
	logic                          ge;

	assign rem_sh = {rem_q, rad_q[rpfm_pkg::SUM_W-1 -: 2]};
	assign trial  = (rpfm_pkg::SREM_W + 2)'({root_q, 2'b01});
	assign ge     = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST)
					busy_q <= 1'b0;
			end
		end
	end

	// one root bit per cycle from two radicand bits
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? rpfm_pkg::SREM_W'(rem_sh - trial) : rpfm_pkg::SREM_W'(rem_sh);
			root_q <= {root_q[rpfm_pkg::ROOT_W-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

FILE: src/rms_power_fault_monitor.sv
// RMS current meter with pump fault monitor.
// Input channel (in_valid/in_stall): kind 0 carries a converter sample in
// sample_mv, kind 1 is a one-second tick. A tick is taken without stalling.
// A sample is squared bit-serially, one multiplier bit per cycle, so it holds
// in_stall while it is squared. The last sample of a 1000-sample window then
// runs a serial divide by the window length, a serial square root and a
// serial volts-times-current product, with in_stall high from acceptance to
// out_valid. Output channel (out_valid/out_stall): one transaction per
// window, held in an output register. While it waits, ticks and samples are
// still taken; only the next window result waits in its final cycle until the
// register frees. Configuration: cfg_wr_en writes cfg_data to register
// cfg_index. The user writes only while idle; the block does not enforce it.
// Reset clears the window sum, sample count, bad-window count and timer and
// loads the register defaults; no result is pending after reset.
`include "rms_power_fault_monitor_defines.svh"

module rms_power_fault_monitor (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [rpfm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rpfm_pkg::CFG_DAT_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              kind,
	input  logic [11:0]                       sample_mv,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [11:0]                       current_ca,
	output logic [19:0]                       power_cw,
	output logic                              pump_ok,
	output logic [7:0]                        bad_count,
	output logic                              backoff_active,
	output logic [15:0]                       backoff_left_s,
	output logic                              pump_trip
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SQ   = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_SQRT = 3'd3;
	localparam logic [2:0] S_MUL  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	localparam logic [rpfm_pkg::CNT_W-1:0]  SEEN_LAST = rpfm_pkg::CNT_W'(rpfm_pkg::SPW - 1);
	localparam logic [rpfm_pkg::CNT_W-1:0]  SEEN_MAX  = rpfm_pkg::CNT_W'(rpfm_pkg::SPW);
	localparam logic [rpfm_pkg::LIM_W-1:0]  CW_SCALE  = rpfm_pkg::LIM_W'(rpfm_pkg::CW_PER_W);
	localparam logic [rpfm_pkg::CNTB_W-1:0] CNT_SAT   = '1;

	logic [2:0]                      state_q;

	logic [rpfm_pkg::DIFF_W-1:0]     offset_q;
	logic [rpfm_pkg::CUR_W-1:0]      gate_q;
	logic [rpfm_pkg::VOLT_W-1:0]     volts_q;
	logic [rpfm_pkg::BAND_W-1:0]     band_low_q;
	logic [rpfm_pkg::BAND_W-1:0]     band_high_q;
	logic [rpfm_pkg::CNTB_W-1:0]     trip_limit_q;
	logic [rpfm_pkg::SEC_W-1:0]      backoff_q;

	logic [rpfm_pkg::CNT_W-1:0]      seen_q;
	logic                            win_end_q;
	logic [rpfm_pkg::CNTB_W-1:0]     bad_windows_q;
	logic                            timer_running_q;
	logic [rpfm_pkg::SEC_W-1:0]      timer_left_q;

	logic [rpfm_pkg::CUR_W-1:0]      cur_q;
	logic [rpfm_pkg::VOLT_W-1:0]     mplier_q;
	logic [rpfm_pkg::PWR_W-1:0]      mcand_q;
	logic [rpfm_pkg::PWR_W-1:0]      pwr_q;

	logic                            out_valid_q;
	logic [rpfm_pkg::CUR_W-1:0]      current_ca_q;
	logic [rpfm_pkg::PWR_W-1:0]      power_cw_q;
	logic                            pump_ok_q;
	logic [rpfm_pkg::CNTB_W-1:0]     bad_count_q;
	logic                            backoff_active_q;
	logic [rpfm_pkg::SEC_W-1:0]      backoff_left_q;
	logic                            pump_trip_q;

	rpfm_pkg::unit_hs_t              sq_hs;
	rpfm_pkg::unit_hs_t              div_hs;
	rpfm_pkg::unit_hs_t              sqrt_hs;
	logic                            sq_clear;
	logic [rpfm_pkg::DIFF_W-1:0]     diff;
	logic [rpfm_pkg::SUM_W-1:0]      sum;
	logic [rpfm_pkg::SUM_W-1:0]      quotient;
	logic [rpfm_pkg::ROOT_W-1:0]     root;

	logic                            in_acc;
	logic                            out_free;
	logic [rpfm_pkg::LIM_W-1:0]      lim_low;
	logic [rpfm_pkg::LIM_W-1:0]      lim_high;
	logic [rpfm_pkg::LIM_W-1:0]      pwr_ext;
	logic                            bad;
	logic [rpfm_pkg::CNTB_W-1:0]     bad_next;
	logic                            trip;
	logic                            start_timer;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign diff = (sample_mv >= offset_q) ? (sample_mv - offset_q) : (offset_q - sample_mv);

	assign sq_hs.start   = in_acc && (kind == rpfm_pkg::KIND_SAMPLE);
	assign div_hs.start  = (state_q == S_SQ) && sq_hs.done && win_end_q;
	assign sq_clear      = div_hs.start;
	assign sqrt_hs.start = (state_q == S_DIV) && div_hs.done;

	rpfm_sqacc u_sqacc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_hs.start),
		.clear  (sq_clear),
		.diff   (diff),
		.sum    (sum),
		.done   (sq_hs.done)
	);

	rpfm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_hs.start),
		.dividend (sum),
		.quotient (quotient),
		.done     (div_hs.done)
	);

	rpfm_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_hs.start),
		.radicand (quotient),
		.root     (root),
		.done     (sqrt_hs.done)
	);

	// fault decision on the finished window
	assign lim_low     = rpfm_pkg::LIM_W'(band_low_q) * CW_SCALE;
	assign lim_high    = rpfm_pkg::LIM_W'(band_high_q) * CW_SCALE;
	assign pwr_ext     = rpfm_pkg::LIM_W'(pwr_q);
	assign bad         = (pwr_ext >= lim_low) && (pwr_ext <= lim_high);
	assign bad_next    = !bad ? '0 :
	                     (bad_windows_q == CNT_SAT) ? CNT_SAT : bad_windows_q + 1'b1;
	assign trip        = bad && (bad_next >= trip_limit_q);
	assign start_timer = trip && !timer_running_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q     <= rpfm_pkg::DIFF_W'(1644);
			gate_q       <= rpfm_pkg::CUR_W'(50);
			volts_q      <= rpfm_pkg::VOLT_W'(120);
			band_low_q   <= rpfm_pkg::BAND_W'(1000);
			band_high_q  <= rpfm_pkg::BAND_W'(1500);
			trip_limit_q <= rpfm_pkg::CNTB_W'(3);
			backoff_q    <= rpfm_pkg::SEC_W'(7200);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				rpfm_pkg::REG_OFFSET:    offset_q     <= cfg_data[rpfm_pkg::DIFF_W-1:0];
				rpfm_pkg::REG_GATE:      gate_q       <= cfg_data[rpfm_pkg::CUR_W-1:0];
				rpfm_pkg::REG_VOLTS:     volts_q      <= cfg_data[rpfm_pkg::VOLT_W-1:0];
				rpfm_pkg::REG_BAND_LOW:  band_low_q   <= cfg_data[rpfm_pkg::BAND_W-1:0];
				rpfm_pkg::REG_BAND_HIGH: band_high_q  <= cfg_data[rpfm_pkg::BAND_W-1:0];
				rpfm_pkg::REG_TRIP:      trip_limit_q <= cfg_data[rpfm_pkg::CNTB_W-1:0];
				rpfm_pkg::REG_BACKOFF:   backoff_q    <= cfg_data[rpfm_pkg::SEC_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			seen_q          <= '0;
			win_end_q       <= 1'b0;
			bad_windows_q   <= '0;
			timer_running_q <= 1'b0;
			timer_left_q    <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (kind == rpfm_pkg::KIND_TICK) begin
							if (timer_running_q) begin
								if (timer_left_q <= rpfm_pkg::SEC_W'(1)) begin
									timer_left_q    <= '0;
									timer_running_q <= 1'b0;
								end else begin
									timer_left_q <= timer_left_q - 1'b1;
								end
							end
						end else begin
							win_end_q <= (seen_q == SEEN_LAST);
							seen_q    <= (seen_q == SEEN_LAST) ? '0 : seen_q + 1'b1;
							state_q   <= S_SQ;
						end
					end
				end
				S_SQ: begin
					if (sq_hs.done)
						state_q <= win_end_q ? S_DIV : S_IDLE;
				end
				S_DIV: begin
					if (div_hs.done)
						state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (sqrt_hs.done)
						state_q <= S_MUL;
				end
				S_MUL: begin
					if (mplier_q[rpfm_pkg::VOLT_W-1:1] == '0)
						state_q <= S_FIN;
				end
				S_FIN: begin
					// hold until the output register is free
					if (out_free) begin
						bad_windows_q <= bad_next;
						if (start_timer) begin
							timer_running_q <= 1'b1;
							timer_left_q    <= backoff_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// serial product volts x current, one volts bit per cycle
	always_ff @(posedge clk) begin
		if (sqrt_hs.done && state_q == S_SQRT) begin
			cur_q    <= (root < rpfm_pkg::ROOT_W'(gate_q)) ? '0 : root[rpfm_pkg::CUR_W-1:0];
			mplier_q <= volts_q;
			mcand_q  <= (root < rpfm_pkg::ROOT_W'(gate_q)) ? '0 :
			            rpfm_pkg::PWR_W'(root[rpfm_pkg::CUR_W-1:0]);
			pwr_q    <= '0;
		end else if (state_q == S_MUL) begin
			if (mplier_q[0])
				pwr_q <= pwr_q + mcand_q;
			mplier_q <= mplier_q >> 1;
			mcand_q  <= mcand_q << 1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			current_ca_q     <= cur_q;
			power_cw_q       <= pwr_q;
			pump_ok_q        <= !bad;
			bad_count_q      <= bad_next;
			backoff_active_q <= timer_running_q || start_timer;
			backoff_left_q   <= timer_left_q;
			pump_trip_q      <= trip;
		end
	end

	assign out_valid      = out_valid_q;
	assign current_ca     = current_ca_q;
	assign power_cw       = power_cw_q;
	assign pump_ok        = pump_ok_q;
	assign bad_count      = bad_count_q;
	assign backoff_active = backoff_active_q;
	assign backoff_left_s = backoff_left_q;
	assign pump_trip      = pump_trip_q;

	`RPFM_ASSERT(a_idle_timer_zero, clk, arst_n, !timer_running_q |-> (timer_left_q == '0), "idle timer holds a nonzero count")
	`RPFM_ASSERT_NEVER(a_seen_range, clk, arst_n, seen_q >= SEEN_MAX, "sample count ran past the window length")
	`RPFM_ASSERT(a_trip_is_bad, clk, arst_n, (out_valid_q && pump_trip_q) |-> (!pump_ok_q && backoff_active_q), "trip reported without a bad window or running timer")
	`RPFM_ASSERT(a_stall_busy, clk, arst_n, (in_acc && kind == rpfm_pkg::KIND_SAMPLE) |=> in_stall, "sample accepted without starting the squarer")

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

	typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_LIGHT} stall_mode_t;

	typedef struct packed {
		logic [11:0] current;
		logic [19:0] power;
		logic        ok;
		logic [7:0]  count;
		logic        active;
		logic [15:0] left;
		logic        trip;
	} window_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        kind;
	logic [11:0] sample_mv;
	logic        out_valid;
	logic        out_stall;
	logic [11:0] current_ca;
	logic [19:0] power_cw;
	logic        pump_ok;
	logic [7:0]  bad_count;
	logic        backoff_active;
	logic [15:0] backoff_left_s;
	logic        pump_trip;

	// meter settings as last written
	logic [11:0] cfg_offset;
	logic [11:0] cfg_gate;
	logic [7:0]  cfg_volts;
	logic [13:0] cfg_band_low;
	logic [13:0] cfg_band_high;
	logic [7:0]  cfg_trip;
	logic [15:0] cfg_backoff;

	// meter state
	logic [35:0] sq_sum;
	int          seen_count;
	logic [7:0]  bad_run;
	logic        timer_on;
	logic [15:0] timer_left;
	logic        pump_on;

	window_result_t pending_windows[$];

	int          errors;
	int          burst_left;
	bit          gapless;
	bit          hold_req;
	int          hold_left;
	int          mode_left;
	stall_mode_t stall_mode;

	rms_power_fault_monitor uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.sample_mv      (sample_mv),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.current_ca     (current_ca),
		.power_cw       (power_cw),
		.pump_ok        (pump_ok),
		.bad_count      (bad_count),
		.backoff_active (backoff_active),
		.backoff_left_s (backoff_left_s),
		.pump_trip      (pump_trip)
	);

	always #5 clk = ~clk;

	function automatic logic [17:0] floor_sqrt(input logic [35:0] v);
		logic [17:0] r;
		logic [35:0] t;
		r = '0;
		for (int b = 17; b >= 0; b--) begin
			t = {18'd0, r | (18'd1 << b)};
			if (t * t <= v)
				r = t[17:0];
		end
		return r;
	endfunction

	task automatic reset_meter_model();
		cfg_offset    = 12'd1644;
		cfg_gate      = 12'd50;
		cfg_volts     = 8'd120;
		cfg_band_low  = 14'd1000;
		cfg_band_high = 14'd1500;
		cfg_trip      = 8'd3;
		cfg_backoff   = 16'd7200;
		sq_sum        = '0;
		seen_count    = 0;
		bad_run       = '0;
		timer_on      = 1'b0;
		timer_left    = '0;
		pump_on       = 1'b1;
	endtask

	// Advance the meter by one accepted transaction; queue a window result when one closes.
	task automatic track_meter(input logic k, input logic [11:0] mv);
		logic [11:0]    d;
		logic [35:0]    mean;
		logic [17:0]    root;
		logic [19:0]    pwr;
		logic           bad;
		logic           trip;
		logic [15:0]    left_then;
		window_result_t r;
		if (k == rpfm_pkg::KIND_TICK) begin
			if (timer_on) begin
				if (timer_left <= 16'd1) begin
					timer_left = '0;
					timer_on   = 1'b0;
				end else begin
					timer_left = timer_left - 16'd1;
				end
			end
			return;
		end
		d = (mv >= cfg_offset) ? mv - cfg_offset : cfg_offset - mv;
		sq_sum = sq_sum + d * d;
		seen_count++;
		if (seen_count < rpfm_pkg::SPW)
			return;
		mean = sq_sum / rpfm_pkg::SPW;
		root = floor_sqrt(mean);
		if (root < cfg_gate)
			root = '0;
		pwr = cfg_volts * root[11:0];
		sq_sum = '0;
		seen_count = 0;
		left_then = timer_left;
		trip = 1'b0;
		bad = (int'(pwr) >= int'(cfg_band_low) * 100) && (int'(pwr) <= int'(cfg_band_high) * 100);
		if (bad) begin
			if (bad_run != 8'd255)
				bad_run = bad_run + 8'd1;
			if (bad_run >= cfg_trip) begin
				trip = 1'b1;
				pump_on = 1'b0;
				if (!timer_on) begin
					timer_on   = 1'b1;
					timer_left = cfg_backoff;
				end
			end
		end else begin
			bad_run = '0;
		end
		r.current = root[11:0];
		r.power   = pwr;
		r.ok      = !bad;
		r.count   = bad_run;
		r.active  = timer_on;
		r.left    = left_then;
		r.trip    = trip;
		pending_windows.push_back(r);
	endtask

	task automatic send_item(input logic k, input logic [11:0] mv);
		if (!gapless && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		sample_mv <= mv;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (burst_left > 0)
			burst_left--;
		track_meter(k, mv);
	endtask

	task automatic send_ticks(input int n);
		logic [11:0] junk;
		for (int i = 0; i < n; i++) begin
			junk = $urandom_range(0, 4095);
			send_item(rpfm_pkg::KIND_TICK, junk);
		end
	endtask

	task automatic send_noise(input int n);
		logic [11:0] mv;
		logic        k;
		for (int i = 0; i < n; i++) begin
			mv = $urandom_range(0, 4095);
			k = ($urandom_range(0, 7) == 0) ? rpfm_pkg::KIND_TICK : rpfm_pkg::KIND_SAMPLE;
			send_item(k, mv);
		end
	endtask

	// Samples at offset +/- (c +/- jit), with ticks mixed in, until the current window closes.
	task automatic send_window(input int c, input int jit, input int tick_pct);
		int off;
		int d;
		int mv;
		off = int'(cfg_offset);
		do begin
			if (int'($urandom_range(0, 99)) < tick_pct)
				send_ticks(1);
			d = c + int'($urandom_range(0, 2 * jit)) - jit;
			if (d < 0)
				d = 0;
			mv = $urandom_range(0, 1) ? off + d : off - d;
			if (mv > 4095)
				mv = off - d;
			if (mv < 0)
				mv = off + d;
			if (mv > 4095)
				mv = 4095;
			send_item(rpfm_pkg::KIND_SAMPLE, mv[11:0]);
		end while (seen_count != 0);
	endtask

	// Drop valid and drain every outstanding window result.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_windows.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[15:0];
		@(posedge clk);
	endtask

	task automatic program_meter(input int off, input int gate, input int volts, input int lo,
			input int hi, input int trip, input int backoff);
		settle();
		write_reg(rpfm_pkg::REG_OFFSET, off);
		write_reg(rpfm_pkg::REG_GATE, gate);
		write_reg(rpfm_pkg::REG_VOLTS, volts);
		write_reg(rpfm_pkg::REG_BAND_LOW, lo);
		write_reg(rpfm_pkg::REG_BAND_HIGH, hi);
		write_reg(rpfm_pkg::REG_TRIP, trip);
		write_reg(rpfm_pkg::REG_BACKOFF, backoff);
		cfg_wr_en <= 1'b0;
		cfg_offset    = off[11:0];
		cfg_gate      = gate[11:0];
		cfg_volts     = volts[7:0];
		cfg_band_low  = lo[13:0];
		cfg_band_high = hi[13:0];
		cfg_trip      = trip[7:0];
		cfg_backoff   = backoff[15:0];
		@(posedge clk);
	endtask

	function automatic int pick(input int lo, input int hi);
		int r;
		r = $urandom_range(0, 3);
		if (r == 0)
			return lo;
		if (r == 1)
			return hi;
		return $urandom_range(lo, hi);
	endfunction

	// Current whose power lands in the bad band, if the band can be reached at all.
	function automatic int band_current();
		int lo;
		int hi;
		int pmax;
		if (cfg_volts == 0 || cfg_band_low > cfg_band_high)
			return $urandom_range(0, 2500);
		lo = int'(cfg_band_low) * 100;
		hi = int'(cfg_band_high) * 100;
		pmax = int'(cfg_volts) * 4095;
		if (lo > pmax)
			return $urandom_range(0, 4095);
		if (hi > pmax)
			hi = pmax;
		return int'($urandom_range(lo, hi)) / int'(cfg_volts);
	endfunction

	task automatic check_field(input string what, input int unsigned want, input int unsigned got);
		if (want != got) begin
			if (errors < 40)
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_checker
		window_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_windows.size() == 0) begin
				if (errors < 40)
					$display("%0t: unexpected window result: expected none, actual current %0d",
						$time, current_ca);
				errors++;
			end else begin
				want = pending_windows.pop_front();
				check_field("current_ca", want.current, current_ca);
				check_field("power_cw", want.power, power_cw);
				check_field("pump_ok", want.ok, pump_ok);
				check_field("bad_count", want.count, bad_count);
				check_field("backoff_active", want.active, backoff_active);
				check_field("backoff_left_s", want.left, backoff_left_s);
				check_field("pump_trip", want.trip, pump_trip);
			end
		end
	end

	// Receiver: shifting stall patterns, or a long hold-off on request.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = 40000;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left  = $urandom_range(20, 300);
			end
			mode_left--;
			case (stall_mode)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_HALF:  out_stall <= $urandom_range(0, 1);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
				default:     out_stall <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	task automatic test_defaults();
		send_ticks(2);
		send_window(2451, 0, 0);
		send_window(1644, 0, 0);
		send_window(0, 0, 0);
		send_ticks(1);
	endtask

	task automatic test_band_and_gate();
		program_meter(2000, 15, 100, 15, 15, 255, 5);
		send_window(15, 0, 0);
		send_window(14, 0, 0);
		program_meter(2000, 0, 100, 15, 15, 255, 5);
		send_window(14, 0, 0);
		send_window(16, 0, 0);
		// low above high: empty band
		program_meter(2000, 0, 100, 16, 15, 255, 5);
		send_window(15, 0, 0);
		send_window(16, 0, 0);
		program_meter(0, 4095, 255, 0, 16383, 255, 5);
		send_window(4095, 0, 0);
		send_window(4094, 0, 0);
	endtask

	task automatic test_trip_and_backoff();
		program_meter(2000, 0, 100, 15, 15, 3, 5);
		send_window(0, 0, 0);
		repeat (3) send_window(15, 0, 0);
		send_ticks(2);
		send_window(15, 0, 0);
		send_window(0, 0, 0);
		send_ticks(3);
		send_window(15, 0, 0);
		program_meter(2000, 0, 100, 15, 15, 0, 5);
		send_window(15, 0, 0);
		send_ticks(6);
		program_meter(2000, 0, 100, 15, 15, 0, 0);
		send_window(15, 0, 0);
		send_window(15, 0, 0);
		send_ticks(1);
		send_window(15, 0, 0);
		send_ticks(1);
		program_meter(2000, 0, 100, 15, 15, 0, 65535);
		send_window(15, 0, 0);
		send_window(15, 0, 0);
		send_ticks(1);
		send_window(15, 0, 0);
	endtask

	task automatic test_count_saturation();
		gapless = 1'b1;
		// zero power with a band starting at zero: every window is bad
		program_meter(0, 0, 255, 0, 16383, 255, 65535);
		for (int w = 0; w < 128; w++) begin
			if (w % 16 == 0)
				send_ticks(1);
			send_window(0, 0, 0);
		end
		program_meter(4095, 0, 255, 0, 16383, 255, 65535);
		for (int w = 0; w < 130; w++) begin
			if (w % 16 == 0)
				send_ticks(1);
			send_window(0, 0, 0);
		end
		gapless = 1'b0;
	endtask

	task automatic test_input_backpressure();
		program_meter(2048, 20, 120, 0, 10000, 2, 30);
		gapless  = 1'b1;
		hold_req = 1'b1;
		repeat (3) send_window($urandom_range(0, 2047), 40, 1);
		gapless = 1'b0;
	endtask

	task automatic test_random_phases();
		int off, gate, volts, lo, hi, trip, backoff;
		int c, tick_pct, tmp;
		for (int p = 0; p < 5; p++) begin
			if (p == 0) begin
				off = 0; gate = 0; volts = 255; lo = 0; hi = 10000; trip = 1; backoff = 1;
			end else if (p == 1) begin
				off = 4095; gate = 4095; volts = 0; lo = 10000; hi = 0; trip = 255;
				backoff = 65535;
			end else begin
				off     = pick(0, 4095);
				gate    = $urandom_range(0, 3) == 0 ? pick(0, 4095) : $urandom_range(0, 200);
				volts   = pick(0, 255);
				lo      = pick(0, 10000);
				hi      = pick(0, 10000);
				trip    = $urandom_range(0, 3) == 0 ? pick(0, 255) : $urandom_range(1, 4);
				backoff = $urandom_range(0, 3) == 0 ? pick(0, 65535) : $urandom_range(1, 60);
				if (lo > hi && $urandom_range(0, 3) != 0) begin
					tmp = lo; lo = hi; hi = tmp;
				end
			end
			program_meter(off, gate, volts, lo, hi, trip, backoff);
			tick_pct = $urandom_range(0, 3);
			for (int w = 0; w < 6; w++) begin
				gapless = ($urandom_range(0, 3) == 0);
				case ($urandom_range(0, 3))
					0, 1: c = band_current();
					2:    c = $urandom_range(0, 4095);
					default: begin
						c = int'(cfg_gate) + int'($urandom_range(0, 4)) - 2;
						if (c < 0) c = 0;
						if (c > 4095) c = 4095;
					end
				endcase
				// break up the window with stray items now and then
				if ($urandom_range(0, 4) == 0)
					send_noise($urandom_range(1, 400));
				send_window(c, $urandom_range(0, 3), tick_pct);
			end
		end
		gapless = 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		kind      = rpfm_pkg::KIND_SAMPLE;
		sample_mv = '0;
		out_stall = 1'b0;
		errors     = 0;
		burst_left = 0;
		gapless    = 1'b0;
		hold_req   = 1'b0;
		hold_left  = 0;
		mode_left  = 0;
		stall_mode = STALL_NONE;
		reset_meter_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_band_and_gate();
		test_trip_and_backoff();
		test_count_saturation();
		test_input_backpressure();
		test_random_phases();

		settle();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#300_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
